// ===== sv/assert_macros.svh =====
// Assertion macros used by the back-end RTL module of the hit merger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pctwhm_pkg.sv =====
// Package with the shared types, field widths and codes of the hit merger.
`timescale 1ns / 1ps

package pctwhm_pkg;

  // Field widths of one input beat and one result beat.
  localparam int CHANNEL_W   = 9;
  localparam int ENERGY_W    = 24;
  localparam int TIME_W      = 32;
  localparam int HIT_INDEX_W = 12;
  localparam int STATUS_W    = 2;
  localparam int HIT_E_W     = 32;
  localparam int COUNT_W     = 16;

  // Command codes of the input channel.
  localparam logic CMD_DEPOSIT = 1'b0;
  localparam logic CMD_EVENT   = 1'b1;

  // Status codes of the result channel.
  localparam logic [STATUS_W-1:0] ST_MERGED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic                 is_event;
    logic [CHANNEL_W-1:0] channel;
    logic [ENERGY_W-1:0]  energy;
    logic [TIME_W-1:0]    time_stamp;
  } item_t;

endpackage

// ===== sv/pctwhm_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module pctwhm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pctwhm_pkg::item_t  push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output pctwhm_pkg::item_t  head_item
);
  import pctwhm_pkg::*;

  localparam int DEPTH = 2;

  item_t      mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  // Status toward both sides.
  assign full       = (count_r == 2'(DEPTH));
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/pctwhm_front.sv =====
// Front end: accepts input beats, drops those without effect, queues the rest.
`timescale 1ns / 1ps

module pctwhm_front #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_cmd,
  input  logic [pctwhm_pkg::CHANNEL_W-1:0]       in_channel,
  input  logic [pctwhm_pkg::ENERGY_W-1:0]        in_energy,
  input  logic [pctwhm_pkg::TIME_W-1:0]          in_time_stamp,
  input  logic                                   q_full,
  input  logic                                   clear_busy,
  output logic                                   push,
  output pctwhm_pkg::item_t                      push_item
);
  import pctwhm_pkg::*;

  logic is_event;
  logic in_range;
  logic keep;

  // Hold the input off while the queue is full or the channel table is swept.
  assign in_stall = q_full || clear_busy;

  // Event starts always go on; a deposit needs energy and a known channel.
  assign is_event = (in_cmd == CMD_EVENT);
  assign in_range = (32'(in_channel) < 32'(NUM_CHANNELS));
  assign keep     = is_event || ((in_energy != '0) && in_range);

  assign push = in_valid && !in_stall && keep;

  always_comb begin
    push_item.is_event   = is_event;
    push_item.channel    = in_channel;
    push_item.energy     = in_energy;
    push_item.time_stamp = in_time_stamp;
  end

endmodule

// ===== sv/pctwhm_back.sv =====
// Back end: channel table and hit store read-modify-write, and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pctwhm_back #(
  parameter int NUM_CHANNELS = 512,
  parameter int MAX_HITS     = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [pctwhm_pkg::TIME_W-1:0]          time_window,
  input  logic                                   q_valid,
  input  pctwhm_pkg::item_t                      q_item,
  output logic                                   q_pop,
  output logic                                   clear_busy,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [pctwhm_pkg::HIT_INDEX_W-1:0]     out_hit_index,
  output logic [pctwhm_pkg::STATUS_W-1:0]        out_status,
  output logic [pctwhm_pkg::HIT_E_W-1:0]         out_hit_energy,
  output logic [pctwhm_pkg::COUNT_W-1:0]         out_interactions
);
  import pctwhm_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HIDX_W = $clog2(MAX_HITS);
  localparam int HU_W   = $clog2(MAX_HITS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHAN,
    S_HIT
  } state_t;

  // Channel table and hit store.
  logic                 chan_open_mem [NUM_CHANNELS];
  logic [HIDX_W-1:0]    chan_idx_mem  [NUM_CHANNELS];
  logic [TIME_W-1:0]    chan_time_mem [NUM_CHANNELS];
  logic [HIT_E_W-1:0]   hit_e_mem     [MAX_HITS];
  logic [COUNT_W-1:0]   hit_n_mem     [MAX_HITS];

  // Registered read data.
  logic                 chan_open_q;
  logic [HIDX_W-1:0]    chan_idx_q;
  logic [TIME_W-1:0]    chan_time_q;
  logic [HIT_E_W-1:0]   hit_e_q;
  logic [COUNT_W-1:0]   hit_n_q;

  // Memory port controls.
  logic                 chan_re;
  logic                 chan_we;
  logic [CH_W-1:0]      chan_addr;
  logic                 chan_wopen;
  logic                 hit_re;
  logic                 hit_we;
  logic [HIDX_W-1:0]    hit_waddr;
  logic [HIT_E_W-1:0]   hit_we_data;
  logic [COUNT_W-1:0]   hit_wn_data;

  // Sequencer state and registered outputs.
  state_t               state_r, state_nxt;
  logic [CH_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  item_t                cur_r, cur_nxt;
  logic [HU_W-1:0]      hits_used_r, hits_used_nxt;
  logic [TIME_W-1:0]    dt_r, dt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [HIT_INDEX_W-1:0] out_hit_index_r, out_hit_index_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [HIT_E_W-1:0]   out_hit_energy_r, out_hit_energy_nxt;
  logic [COUNT_W-1:0]   out_interactions_r, out_interactions_nxt;

  // Update datapath.
  logic                 out_free;
  logic                 merge;
  logic                 store_full;
  logic                 ld_full;
  logic [HIT_E_W:0]     sum_w;
  logic [HIT_E_W-1:0]   sum_sat;
  logic [COUNT_W-1:0]   n_inc;

  assign out_free   = !out_valid_r || !out_stall;
  assign merge      = chan_open_q && (dt_r < time_window);
  assign store_full = (hits_used_r == HU_W'(MAX_HITS));
  assign sum_w      = {1'b0, hit_e_q} + (HIT_E_W + 1)'(cur_r.energy);
  assign sum_sat    = sum_w[HIT_E_W] ? '1 : sum_w[HIT_E_W-1:0];
  assign n_inc      = (hit_n_q == '1) ? hit_n_q : hit_n_q + COUNT_W'(1);
  assign ld_full    = (state_r == S_HIT) && out_free && !merge && store_full;

  assign clear_busy = (state_r == S_CLEAR);
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  // Sequencer: clearing sweep, channel read, hit read, update.
  always_comb begin
    state_nxt            = state_r;
    clr_cnt_nxt          = clr_cnt_r;
    cur_nxt              = cur_r;
    hits_used_nxt        = hits_used_r;
    dt_nxt               = dt_r;
    out_valid_nxt        = out_valid_r && out_stall;
    out_hit_index_nxt    = out_hit_index_r;
    out_status_nxt       = out_status_r;
    out_hit_energy_nxt   = out_hit_energy_r;
    out_interactions_nxt = out_interactions_r;
    chan_re              = 1'b0;
    chan_we              = 1'b0;
    chan_addr            = CH_W'(cur_r.channel);
    chan_wopen           = 1'b0;
    hit_re               = 1'b0;
    hit_we               = 1'b0;
    hit_waddr            = chan_idx_q;
    hit_we_data          = sum_sat;
    hit_wn_data          = n_inc;
    unique case (state_r)
      S_CLEAR: begin
        chan_we   = 1'b1;
        chan_addr = clr_cnt_r;
        if (clr_cnt_r == CH_W'(NUM_CHANNELS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + CH_W'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_item;
          if (q_item.is_event) begin
            hits_used_nxt = '0;
            clr_cnt_nxt   = '0;
            state_nxt     = S_CLEAR;
          end else begin
            chan_re   = 1'b1;
            chan_addr = CH_W'(q_item.channel);
            state_nxt = S_CHAN;
          end
        end
      end
      S_CHAN: begin
        // Distance to the open hit's first time, never wrapping.
        dt_nxt    = (chan_time_q > cur_r.time_stamp) ? (chan_time_q - cur_r.time_stamp)
                                                     : (cur_r.time_stamp - chan_time_q);
        hit_re    = 1'b1;
        state_nxt = S_HIT;
      end
      S_HIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          priority if (merge) begin
            hit_we               = 1'b1;
            out_hit_index_nxt    = HIT_INDEX_W'(chan_idx_q);
            out_status_nxt       = ST_MERGED;
            out_hit_energy_nxt   = sum_sat;
            out_interactions_nxt = n_inc;
          end else if (store_full) begin
            out_hit_index_nxt    = '0;
            out_status_nxt       = ST_FULL;
            out_hit_energy_nxt   = '0;
            out_interactions_nxt = '0;
          end else begin
            // Open a new hit and point the channel at it.
            hit_we               = 1'b1;
            hit_waddr            = HIDX_W'(hits_used_r);
            hit_we_data          = HIT_E_W'(cur_r.energy);
            hit_wn_data          = COUNT_W'(1);
            chan_we              = 1'b1;
            chan_wopen           = 1'b1;
            hits_used_nxt        = hits_used_r + HU_W'(1);
            out_hit_index_nxt    = HIT_INDEX_W'(hits_used_r);
            out_status_nxt       = ST_NEW;
            out_hit_energy_nxt   = HIT_E_W'(cur_r.energy);
            out_interactions_nxt = COUNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; a clearing sweep runs after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hits_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hits_used_r <= hits_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r              <= cur_nxt;
    dt_r               <= dt_nxt;
    out_hit_index_r    <= out_hit_index_nxt;
    out_status_r       <= out_status_nxt;
    out_hit_energy_r   <= out_hit_energy_nxt;
    out_interactions_r <= out_interactions_nxt;
  end

  // Channel table: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (chan_we) begin
      chan_open_mem[chan_addr] <= chan_wopen;
      chan_idx_mem[chan_addr]  <= HIDX_W'(hits_used_r);
      chan_time_mem[chan_addr] <= cur_r.time_stamp;
    end
    if (chan_re) begin
      chan_open_q <= chan_open_mem[chan_addr];
      chan_idx_q  <= chan_idx_mem[chan_addr];
      chan_time_q <= chan_time_mem[chan_addr];
    end
  end

  // Hit store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_e_mem[hit_waddr] <= hit_we_data;
      hit_n_mem[hit_waddr] <= hit_wn_data;
    end
    if (hit_re) begin
      hit_e_q <= hit_e_mem[chan_idx_q];
      hit_n_q <= hit_n_mem[chan_idx_q];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit_index    = out_hit_index_r;
  assign out_status       = out_status_r;
  assign out_hit_energy   = out_hit_energy_r;
  assign out_interactions = out_interactions_r;

  // The hit counter never runs past the store size.
  `ASSERT_IMPL(a_hits_bound, 1'b1, hits_used_r <= HU_W'(MAX_HITS), "hit counter overflow")
  // A freshly opened hit reports a single interaction.
  `ASSERT_IMPL(a_new_hit_count, out_valid_r && (out_status_r == ST_NEW),
               out_interactions_r == COUNT_W'(1), "new hit count is not one")
  // A dropped deposit leaves the store full.
  `ASSERT_NEXT(a_full_stays, ld_full, hits_used_r == HU_W'(MAX_HITS), "full drop changed counter")
  // Nothing leaves the queue during a clearing sweep.
  `ASSERT_IMPL(a_clear_no_pop, state_r == S_CLEAR, !q_pop, "pop during clearing sweep")
  // A pending update waits while the result register is held.
  `ASSERT_NEXT(a_hit_waits, (state_r == S_HIT) && !out_free, state_r == S_HIT,
               "update left while result held")

endmodule

// ===== sv/per_channel_time_window_hit_merger_top.sv =====
// Top level of the per-channel time-window hit merger.
// Deposits are merged per channel into hits by time window. The front end takes one beat
// per cycle into a two-entry queue while in_stall is low, and drops zero-energy and
// out-of-range beats at once. The back end handles one deposit at a time (channel table
// read, hit store read, update), a read-modify-write through the channel table and the
// hit store. An event start sweeps the channel table, one entry a cycle, over every
// entry. After reset the same sweep runs while in_stall is held high; configuration
// writes are taken throughout. A result waits in an output register, so the back end
// can read the next deposit while it stalls; the update waits until the register is free.
`timescale 1ns / 1ps

module per_channel_time_window_hit_merger_top #(
  parameter int NUM_CHANNELS = 512,
  parameter int MAX_HITS     = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pctwhm_pkg::TIME_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [pctwhm_pkg::CHANNEL_W-1:0]     in_channel,
  input  logic [pctwhm_pkg::ENERGY_W-1:0]      in_energy,
  input  logic [pctwhm_pkg::TIME_W-1:0]        in_time_stamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pctwhm_pkg::HIT_INDEX_W-1:0]   out_hit_index,
  output logic [pctwhm_pkg::STATUS_W-1:0]      out_status,
  output logic [pctwhm_pkg::HIT_E_W-1:0]       out_hit_energy,
  output logic [pctwhm_pkg::COUNT_W-1:0]       out_interactions
);
  import pctwhm_pkg::*;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;

  logic [TIME_W-1:0] time_window_r;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              push;
  logic              clear_busy;
  item_t             push_item;
  item_t             q_item;

  // Merge window register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      time_window_r <= cfg_wdata;
    end
  end

  pctwhm_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_channel    (in_channel),
    .in_energy     (in_energy),
    .in_time_stamp (in_time_stamp),
    .q_full        (q_full),
    .clear_busy    (clear_busy),
    .push          (push),
    .push_item     (push_item)
  );

  pctwhm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  pctwhm_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_HITS     (MAX_HITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .time_window      (time_window_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .clear_busy       (clear_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_index    (out_hit_index),
    .out_status       (out_status),
    .out_hit_energy   (out_hit_energy),
    .out_interactions (out_interactions)
  );

endmodule
